// ----- rtl/core/toroidal_3d_life_step_assert.svh -----
// Assertion macros used by the 3D life step controller.
`ifndef TOROIDAL_3D_LIFE_STEP_ASSERT_SVH
`define TOROIDAL_3D_LIFE_STEP_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TLS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define TLS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TLS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TLS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/tls_pkg.sv -----
// Package: constants, types and tap tables for the 3D life step block.
`default_nettype none
package tls_pkg;
   localparam int GRID_SIDE = 16;
   localparam int SIDE_BITS = 4;
   localparam int ROW_BITS  = 2 * SIDE_BITS;
   localparam int ROWS      = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_BITS = ROW_BITS + 1;
   localparam int MEM_DEPTH = 2 * ROWS;
   localparam int CNT_BITS  = 5;
   localparam int CFG_BITS  = 5;
   localparam int TAP_BITS  = 4;

   localparam logic [TAP_BITS-1:0] TAP_FIRST  = 4'd0;
   localparam logic [TAP_BITS-1:0] TAP_CENTER = 4'd5; // data of the center row arrives here
   localparam logic [TAP_BITS-1:0] TAP_LAST   = 4'd9;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_STEP  = 2'd2;

   localparam logic [1:0] CSR_SURV_LO  = 2'd0;
   localparam logic [1:0] CSR_SURV_HI  = 2'd1;
   localparam logic [1:0] CSR_BIRTH_LO = 2'd2;
   localparam logic [1:0] CSR_BIRTH_HI = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DISPATCH, ST_RMW_RD, ST_RMW_WR, ST_RD, ST_STEP_RD, ST_STEP_WR, ST_DONE
   } tls_state_type;

   typedef struct packed {
      logic rd_item;
      logic wr_item;
      logic step_rd;
      logic step_wr;
      logic step_end;
      logic rsp_load;
   } tls_cmd_type;

   typedef struct packed {
      logic [1:0] act;
      logic       k_last;
      logic       row_last;
      logic       rsp_free;
   } tls_stat_type;

   // x offset (mod GRID_SIDE) of neighbor row tap k
   function automatic logic [SIDE_BITS-1:0] tap_dx(input logic [TAP_BITS-1:0] k);
      logic [SIDE_BITS-1:0] r;
      case (k)
         4'd0, 4'd1, 4'd2: r = '1;
         4'd6, 4'd7, 4'd8: r = SIDE_BITS'(1);
         default:          r = '0;
      endcase
      return r;
   endfunction

   // y offset (mod GRID_SIDE) of neighbor row tap k
   function automatic logic [SIDE_BITS-1:0] tap_dy(input logic [TAP_BITS-1:0] k);
      logic [SIDE_BITS-1:0] r;
      case (k)
         4'd0, 4'd3, 4'd6: r = '1;
         4'd2, 4'd5, 4'd8: r = SIDE_BITS'(1);
         default:          r = '0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/core/tls_ctrl.sv -----
// Controller: sequences cell writes, reads and generation sweeps.
`default_nettype none
`include "toroidal_3d_life_step_assert.svh"
module tls_ctrl
   import tls_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire tls_stat_type stat,
   output tls_cmd_type       cmd
);
   tls_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            case (stat.act)
               ACT_WRITE: state_in = ST_RMW_RD;
               ACT_READ:  state_in = ST_RD;
               ACT_STEP:  state_in = ST_STEP_RD;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_RMW_RD:   state_in = ST_RMW_WR;
         ST_RMW_WR:   state_in = ST_DONE;
         ST_RD:       state_in = ST_DONE;
         ST_STEP_RD:  if (stat.k_last) state_in = ST_STEP_WR;
         ST_STEP_WR:  state_in = stat.row_last ? ST_DONE : ST_STEP_RD;
         ST_DONE:     if (stat.rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_RMW_RD:  cmd.rd_item = 1'b1;
         ST_RMW_WR:  cmd.wr_item = 1'b1;
         ST_RD:      cmd.rd_item = 1'b1;
         ST_STEP_RD: cmd.step_rd = 1'b1;
         ST_STEP_WR: begin
            cmd.step_wr  = 1'b1;
            cmd.step_end = stat.row_last;
         end
         ST_DONE:    cmd.rsp_load = stat.rsp_free;
         default:    cmd = '0;
      endcase
   end

   `TLS_ASSERT_IMPL(a_rmw_order, clock, reset, state_ff == ST_RMW_WR, $past(state_ff) == ST_RMW_RD)
   `TLS_ASSERT_IMPL(a_wr_after_taps, clock, reset, state_ff == ST_STEP_WR, $past(state_ff) == ST_STEP_RD && $past(stat.k_last))
   `TLS_ASSERT_NEXT(a_done_holds, clock, reset, state_ff == ST_DONE && !stat.rsp_free, state_ff == ST_DONE)
endmodule
`default_nettype wire

// ----- rtl/core/tls_dpath.sv -----
// Datapath: grid memory, neighbor counters, rule logic, config and result registers.
`default_nettype none
module tls_dpath
   import tls_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_load,
   input  wire logic [15:0]         req_tdata,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [CFG_BITS-1:0] csr_wdata,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [7:0]               rsp_tdata,
   input  wire tls_cmd_type         cmd,
   output tls_stat_type             stat
);
   logic [1:0]           act_ff;
   logic [SIDE_BITS-1:0] px_ff, py_ff, pz_ff;
   logic                 wv_ff;
   logic [CFG_BITS-1:0]  surv_lo_ff, surv_hi_ff, birth_lo_ff, birth_hi_ff;
   logic                 bank_ff;
   logic [ROWS-1:0]      row_valid_ff;
   logic [ROW_BITS-1:0]  row_ff;
   logic [TAP_BITS-1:0]  k_ff;
   logic [GRID_SIDE-1:0] grid_mem [MEM_DEPTH];
   logic [GRID_SIDE-1:0] rd_data_ff, self_row_ff;
   logic                 rd_valid_ff;
   logic [CNT_BITS-1:0]  cnt_ff [GRID_SIDE];
   logic [CNT_BITS-1:0]  cnt_in [GRID_SIDE];
   logic                 rsp_valid_ff, rsp_alive_ff;

   logic [ROW_BITS-1:0]  rd_row, wr_row;
   logic [ADDR_BITS-1:0] rd_addr, wr_addr;
   logic                 rd_en, wr_en;
   logic [GRID_SIDE-1:0] wr_data, tap_data, merged_row, next_row;
   logic                 center;

   // item and config capture
   always_ff @(posedge clock) begin
      if (req_load) begin
         act_ff <= req_tdata[1:0];
         px_ff  <= req_tdata[5:2];
         py_ff  <= req_tdata[9:6];
         pz_ff  <= req_tdata[13:10];
         wv_ff  <= req_tdata[14];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surv_lo_ff  <= CFG_BITS'(1);
         surv_hi_ff  <= CFG_BITS'(10);
         birth_lo_ff <= CFG_BITS'(1);
         birth_hi_ff <= CFG_BITS'(10);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SURV_LO:  surv_lo_ff  <= csr_wdata;
            CSR_SURV_HI:  surv_hi_ff  <= csr_wdata;
            CSR_BIRTH_LO: birth_lo_ff <= csr_wdata;
            CSR_BIRTH_HI: birth_hi_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // memory addressing: rows are (x,y), a row holds all z cells; bank picks the live copy
   always_comb begin
      rd_row  = cmd.step_rd ? {row_ff[ROW_BITS-1:SIDE_BITS] + tap_dx(k_ff),
                               row_ff[SIDE_BITS-1:0] + tap_dy(k_ff)}
                            : {px_ff, py_ff};
      rd_addr = {bank_ff, rd_row};
      rd_en   = cmd.rd_item | (cmd.step_rd & (k_ff != TAP_LAST));
      wr_row  = cmd.step_wr ? row_ff : {px_ff, py_ff};
      wr_addr = {bank_ff ^ cmd.step_wr, wr_row};
      wr_en   = cmd.wr_item | cmd.step_wr;
      merged_row = tap_data;
      merged_row[pz_ff] = wv_ff;
      wr_data = cmd.step_wr ? next_row : merged_row;
   end

   always_ff @(posedge clock) begin
      if (wr_en) grid_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= grid_mem[rd_addr];
   end

   // row valid bits stand in for clearing the memory after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         bank_ff      <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (rd_en) rd_valid_ff <= row_valid_ff[rd_row];
         if (cmd.wr_item) row_valid_ff[wr_row] <= 1'b1;
         if (cmd.step_end) begin
            row_valid_ff <= '1;
            bank_ff      <= ~bank_ff;
         end
      end
   end

   assign tap_data = rd_valid_ff ? rd_data_ff : '0;
   assign center   = (k_ff == TAP_CENTER);

   // sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= TAP_FIRST;
         row_ff <= '0;
      end else if (cmd.step_wr) begin
         k_ff   <= TAP_FIRST;
         row_ff <= row_ff + ROW_BITS'(1);
      end else if (cmd.step_rd) begin
         k_ff   <= k_ff + TAP_BITS'(1);
      end
   end

   // per-lane neighbor counts, one tap row a cycle
   always_comb begin
      for (int z = 0; z < GRID_SIDE; z++) begin
         cnt_in[z] = cnt_ff[z]
                   + CNT_BITS'(tap_data[(z + GRID_SIDE - 1) % GRID_SIDE])
                   + CNT_BITS'(tap_data[(z + 1) % GRID_SIDE])
                   + CNT_BITS'(tap_data[z] & ~center);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_rd) begin
         for (int z = 0; z < GRID_SIDE; z++)
            cnt_ff[z] <= (k_ff == TAP_FIRST) ? '0 : cnt_in[z];
         if (center) self_row_ff <= tap_data;
      end
   end

   // survive and birth rule
   always_comb begin
      for (int z = 0; z < GRID_SIDE; z++) begin
         if (self_row_ff[z])
            next_row[z] = (cnt_ff[z] >= surv_lo_ff) && (cnt_ff[z] <= surv_hi_ff);
         else
            next_row[z] = (cnt_ff[z] >= birth_lo_ff) && (cnt_ff[z] <= birth_hi_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (cmd.rsp_load) rsp_alive_ff <= (act_ff == ACT_READ) & tap_data[pz_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_alive_ff};

   assign stat.act      = act_ff;
   assign stat.k_last   = (k_ff == TAP_LAST);
   assign stat.row_last = (row_ff == '1);
   assign stat.rsp_free = ~rsp_valid_ff | rsp_tready;
endmodule
`default_nettype wire

// ----- rtl/core/toroidal_3d_life_step.sv -----
// Top level of the toroidal 3D life step block.
//
//  channel | dir | transfer when          | payload
//  req     | in  | req_tvalid & tready    | action, pos_x, pos_y, pos_z, write_alive
//  rsp     | out | rsp_tvalid & tready    | cell_alive
//  csr     | in  | csr_we                 | csr_index, csr_wdata
//
// A read does one grid memory read; a write reads its row, merges the new cell and
// writes the row back; a generation sweeps each (x,y) row of 16 cells
// (9 neighbor-row reads, one drain, one write). Reset is synchronous; the grid
// reads as all dead through per-row valid bits, so there is no clearing pass.
// A new request is taken once the previous result sits in the result register;
// a result held by rsp_tready low keeps the controller in its done state.
`default_nettype none
module toroidal_3d_life_step
   import tls_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [15:0]         req_tdata,  // action[1:0] pos_x[5:2] pos_y[9:6] pos_z[13:10] write_alive[14]
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata,  // cell_alive[0]
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [CFG_BITS-1:0] csr_wdata
);
   tls_cmd_type  cmd;
   tls_stat_type stat;

   tls_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .stat, .cmd
   );

   tls_dpath u_dpath (
      .clock, .reset,
      .req_load (req_tvalid & req_tready),
      .req_tdata, .csr_we, .csr_index, .csr_wdata,
      .rsp_tready, .rsp_tvalid, .rsp_tdata, .cmd, .stat
   );
endmodule
`default_nettype wire
